// ===== src/mvn_pkg.sv =====
// Package for the mesh vertex normal and fan triangulation block.
// Holds sizes, opcodes, command and status types shared by all modules.
// No dependencies.
package mvn_pkg;

    localparam int VERTEX_DEPTH = 1024;
    localparam int SUM_WIDTH    = 24;
    localparam int ADDR_W       = $clog2(VERTEX_DEPTH);
    localparam int IDX_W        = 10;
    localparam int POS_W        = 16;
    localparam int NRM_W        = 16;
    localparam int DIFF_W       = POS_W + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int NORM_IN_W    = 36;
    localparam int MAG_W        = 24;
    localparam int S_TDATA_W    = 64;
    localparam int M_TDATA_W    = 80;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_CORNER = 2'd1,
        OP_READ   = 2'd2
    } opcode_t;

    typedef enum logic {
        KIND_TRI    = 1'b0,
        KIND_NORMAL = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        SEL_FIRST  = 2'd0,
        SEL_SECOND = 2'd1,
        SEL_CUR    = 2'd2
    } corner_sel_t;

    typedef struct packed {
        logic        accept;
        logic        clr_step;
        logic        pos_write;
        logic        corner_short;
        logic        sum_rd;
        logic        norm_start_sum;
        logic        pos_rd;
        logic        pos_cap;
        corner_sel_t sel;
        corner_sel_t cap_sel;
        logic        diff_load;
        logic        mul_start;
        logic        norm_start_cross;
        logic        face_load;
        logic        add_rd;
        logic        add_wr;
        logic        tri_emit;
        logic        norm_emit;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic [1:0] count;
        logic       clr_done;
        logic       mul_done;
        logic       norm_done;
        logic       out_free;
    } dp_status_t;

    function automatic logic in_range(input logic [IDX_W-1:0] idx);
        return 32'(idx) < VERTEX_DEPTH;
    endfunction

    function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] idx);
        logic [31:0] w;
        w = 32'(idx);
        return w[ADDR_W-1:0];
    endfunction

endpackage

// ===== src/mesh_vertex_normals_fan_triangulate_top.sv =====
// Top level of the mesh vertex normal accumulator with fan triangulation.
// Joins the controller and the datapath. Depends on mvn_pkg, mvn_ctrl, mvn_dp.
//
//  Channel  Direction  Contents
//  s_*      in         tuser opcode, tlast last corner, tdata index and position
//  m_*      out        tuser result kind, tdata triangle indices or normal
//
// One transaction is worked on at a time. A vertex write, a first or second
// corner and a later corner are short. A normal read and a third corner run the
// shared iterative normalizer with at most 23 scaling steps, which a zero sum
// or a zero face skips. After reset a clearing pass zeroes the normal sums.
// A result waits in the output register while the next transaction is taken.
module mesh_vertex_normals_fan_triangulate_top
    import mvn_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // vertex_index, pos_x, pos_y, pos_z
    input  logic [1:0]           s_tuser,  // opcode
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // tri_first, tri_second, tri_third,
                                           // normal_x, normal_y, normal_z
    output logic                 m_tuser   // result_kind
);

    dp_cmd_t    cmd;
    dp_status_t status;

    mvn_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mvn_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== src/mvn_norm.sv =====
// Iterative vector normalizer: scales a vector to unit length in signed Q1.14.
// Shift search, sum of squares, bit-serial square root and restoring division.
// Depends on mvn_pkg.
module mvn_norm
    import mvn_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic signed [NORM_IN_W-1:0] vec_x,
    input  logic signed [NORM_IN_W-1:0] vec_y,
    input  logic signed [NORM_IN_W-1:0] vec_z,
    output logic                        done,
    output logic signed [NRM_W-1:0]     q_x,
    output logic signed [NRM_W-1:0]     q_y,
    output logic signed [NRM_W-1:0]     q_z
);

    localparam int SQ_W    = 2 * MAG_W;
    localparam int ACC_W   = SQ_W + 2;
    localparam int LEN_W   = MAG_W + 1;
    localparam int QB_W    = 16;
    localparam int REM_W   = LEN_W + 1 + QB_W - 1;
    localparam int SQRT_N  = ACC_W / 2;
    localparam int IT_W    = $clog2(SQRT_N);
    localparam int BCNT_W  = $clog2(QB_W);
    localparam logic [QB_W-1:0] Q_ONE = QB_W'(16384);

    typedef enum logic [6:0] {
        N_IDLE  = 7'b0000001,
        N_SHIFT = 7'b0000010,
        N_SQ    = 7'b0000100,
        N_SQRT  = 7'b0001000,
        N_DLD   = 7'b0010000,
        N_DIV   = 7'b0100000,
        N_DONE  = 7'b1000000
    } nstate_t;

    nstate_t                state_reg;
    logic [NORM_IN_W-1:0]   mag_reg [3];
    logic                   neg_reg [3];
    logic signed [NRM_W-1:0] q_reg  [3];
    logic [1:0]             cnt_reg;
    logic [1:0]             comp_reg;
    logic [SQ_W-1:0]        sq_reg;
    logic [ACC_W-1:0]       acc_reg;
    logic [ACC_W-1:0]       x_reg;
    logic [ACC_W-1:0]       r_reg;
    logic [ACC_W-1:0]       bit_reg;
    logic [IT_W-1:0]        it_reg;
    logic [REM_W-1:0]       rem_reg;
    logic [REM_W-1:0]       dsh_reg;
    logic [QB_W-1:0]        qb_reg;
    logic [BCNT_W-1:0]      bcnt_reg;

    logic [NORM_IN_W-1:0]   orv;
    logic [ACC_W-1:0]       trial;
    logic                   ge;
    logic [QB_W-1:0]        qn;
    logic [QB_W-1:0]        qc;
    logic [LEN_W-1:0]       len;

    assign orv   = mag_reg[0] | mag_reg[1] | mag_reg[2];
    assign trial = r_reg + bit_reg;
    assign ge    = rem_reg >= dsh_reg;
    assign qn    = {qb_reg[QB_W-2:0], ge};
    assign qc    = (qn > Q_ONE) ? Q_ONE : qn;
    assign len   = r_reg[LEN_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= N_IDLE;
        end else begin
            case (state_reg)
                N_IDLE: begin
                    if (start) begin
                        if (vec_x == '0 && vec_y == '0 && vec_z == '0) begin
                            state_reg <= N_DONE;
                        end else begin
                            state_reg <= N_SHIFT;
                        end
                    end
                end
                N_SHIFT: begin
                    if (orv[NORM_IN_W-1:MAG_W] == '0 && orv[MAG_W-1]) begin
                        state_reg <= N_SQ;
                    end
                end
                N_SQ: begin
                    if (cnt_reg == 2'd3) begin
                        state_reg <= N_SQRT;
                    end
                end
                N_SQRT: begin
                    if (it_reg == IT_W'(SQRT_N - 1)) begin
                        state_reg <= N_DLD;
                    end
                end
                N_DLD: begin
                    state_reg <= N_DIV;
                end
                N_DIV: begin
                    if (bcnt_reg == '0) begin
                        state_reg <= (comp_reg == 2'd2) ? N_DONE : N_DLD;
                    end
                end
                N_DONE: begin
                    state_reg <= N_IDLE;
                end
                default: begin
                    state_reg <= N_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            N_IDLE: begin
                if (start) begin
                    mag_reg[0] <= vec_x[NORM_IN_W-1] ? NORM_IN_W'(-vec_x) : NORM_IN_W'(vec_x);
                    mag_reg[1] <= vec_y[NORM_IN_W-1] ? NORM_IN_W'(-vec_y) : NORM_IN_W'(vec_y);
                    mag_reg[2] <= vec_z[NORM_IN_W-1] ? NORM_IN_W'(-vec_z) : NORM_IN_W'(vec_z);
                    neg_reg[0] <= vec_x[NORM_IN_W-1];
                    neg_reg[1] <= vec_y[NORM_IN_W-1];
                    neg_reg[2] <= vec_z[NORM_IN_W-1];
                    for (int i = 0; i < 3; i++) begin
                        q_reg[i] <= '0;
                    end
                end
            end
            N_SHIFT: begin
                if (orv[NORM_IN_W-1:MAG_W] != '0) begin
                    for (int i = 0; i < 3; i++) begin
                        mag_reg[i] <= mag_reg[i] >> 1;
                    end
                end else if (!orv[MAG_W-1]) begin
                    for (int i = 0; i < 3; i++) begin
                        mag_reg[i] <= mag_reg[i] << 1;
                    end
                end else begin
                    cnt_reg <= '0;
                    acc_reg <= '0;
                end
            end
            N_SQ: begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg != 2'd3) begin
                    sq_reg     <= mag_reg[0][MAG_W-1:0] * mag_reg[0][MAG_W-1:0];
                    mag_reg[0] <= mag_reg[1];
                    mag_reg[1] <= mag_reg[2];
                    mag_reg[2] <= mag_reg[0];
                    neg_reg[0] <= neg_reg[1];
                    neg_reg[1] <= neg_reg[2];
                    neg_reg[2] <= neg_reg[0];
                end
                if (cnt_reg != 2'd0) begin
                    acc_reg <= acc_reg + ACC_W'(sq_reg);
                end
                if (cnt_reg == 2'd3) begin
                    x_reg   <= acc_reg + ACC_W'(sq_reg);
                    r_reg   <= '0;
                    bit_reg <= ACC_W'(1) << (ACC_W - 2);
                    it_reg  <= '0;
                end
            end
            N_SQRT: begin
                if (x_reg >= trial) begin
                    x_reg <= x_reg - trial;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end else begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                it_reg  <= it_reg + IT_W'(1);
                comp_reg <= '0;
            end
            N_DLD: begin
                rem_reg  <= (REM_W'(mag_reg[0][MAG_W-1:0]) << (QB_W - 1)) + REM_W'(len);
                dsh_reg  <= REM_W'({len, 1'b0}) << (QB_W - 1);
                bcnt_reg <= BCNT_W'(QB_W - 1);
                qb_reg   <= '0;
            end
            N_DIV: begin
                if (ge) begin
                    rem_reg <= rem_reg - dsh_reg;
                end
                qb_reg   <= qn;
                dsh_reg  <= dsh_reg >> 1;
                bcnt_reg <= bcnt_reg - BCNT_W'(1);
                if (bcnt_reg == '0) begin
                    q_reg[0]   <= q_reg[1];
                    q_reg[1]   <= q_reg[2];
                    q_reg[2]   <= neg_reg[0] ? -$signed(qc) : $signed(qc);
                    mag_reg[0] <= mag_reg[1];
                    mag_reg[1] <= mag_reg[2];
                    mag_reg[2] <= mag_reg[0];
                    neg_reg[0] <= neg_reg[1];
                    neg_reg[1] <= neg_reg[2];
                    neg_reg[2] <= neg_reg[0];
                    comp_reg   <= comp_reg + 2'd1;
                end
            end
            default: begin
            end
        endcase
    end

    assign done = (state_reg == N_DONE);
    assign q_x  = q_reg[0];
    assign q_y  = q_reg[1];
    assign q_z  = q_reg[2];

    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> (q_x <= 16384 && q_x >= -16384 && q_y <= 16384 && q_y >= -16384
                  && q_z <= 16384 && q_z >= -16384))
        else $error("normalized component out of unit range");

    a_scaled: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == N_SQ && cnt_reg == 2'd0)
            |-> (orv[MAG_W-1] && orv[NORM_IN_W-1:MAG_W] == '0))
        else $error("squaring started on a vector that is not scaled");

endmodule

// ===== src/mvn_dp.sv =====
// Datapath: position and normal-sum memories, item and corner registers,
// cross product unit, saturating accumulation and output register.
// Depends on mvn_pkg and mvn_norm.
module mvn_dp
    import mvn_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [1:0]            s_tuser,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tuser
);

    localparam int PW = 3 * POS_W;
    localparam int SW = 3 * SUM_WIDTH;

    function automatic logic signed [SUM_WIDTH-1:0] sat_add(
        input logic signed [SUM_WIDTH-1:0] s,
        input logic signed [NRM_W-1:0]     a
    );
        logic signed [SUM_WIDTH:0] r;
        r = (SUM_WIDTH + 1)'(s) + (SUM_WIDTH + 1)'(a);
        if (r[SUM_WIDTH] != r[SUM_WIDTH-1]) begin
            return r[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH - 1){1'b0}}}
                                : {1'b0, {(SUM_WIDTH - 1){1'b1}}};
        end
        return r[SUM_WIDTH-1:0];
    endfunction

    logic [1:0]            op_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [PW-1:0]         pos_reg;
    logic                  last_reg;
    logic [IDX_W-1:0]      first_reg;
    logic [IDX_W-1:0]      second_reg;
    logic [IDX_W-1:0]      prev_reg;
    logic [1:0]            count_reg;
    logic [ADDR_W-1:0]     clr_cnt_reg;

    logic [PW-1:0]         pos_mem [VERTEX_DEPTH];
    logic [SW-1:0]         sum_mem [VERTEX_DEPTH];
    logic [PW-1:0]         pos_rdata_reg;
    logic                  pos_rng_reg;
    logic [SW-1:0]         sum_rdata_reg;
    logic                  sum_rng_reg;

    logic [PW-1:0]         p0_reg;
    logic [PW-1:0]         p1_reg;
    logic [PW-1:0]         p2_reg;
    logic signed [DIFF_W-1:0] a_reg [3];
    logic signed [DIFF_W-1:0] b_reg [3];
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [NORM_IN_W-1:0] cx_reg;
    logic signed [NORM_IN_W-1:0] cy_reg;
    logic signed [NORM_IN_W-1:0] cz_reg;
    logic                  mul_busy_reg;
    logic [2:0]            mul_cnt_reg;

    logic signed [NRM_W-1:0] fx_reg;
    logic signed [NRM_W-1:0] fy_reg;
    logic signed [NRM_W-1:0] fz_reg;

    logic                  m_valid_reg;
    logic [M_TDATA_W-1:0]  m_data_reg;
    logic                  m_user_reg;

    logic [IDX_W-1:0]      sel_idx;
    logic [PW-1:0]         cap_word;
    logic signed [DIFF_W-1:0] fa;
    logic signed [DIFF_W-1:0] fb;
    logic                  sum_we;
    logic [ADDR_W-1:0]     sum_waddr;
    logic [SW-1:0]         sum_wdata;
    logic [SW-1:0]         sum_add;
    logic signed [NORM_IN_W-1:0] nv_x;
    logic signed [NORM_IN_W-1:0] nv_y;
    logic signed [NORM_IN_W-1:0] nv_z;
    logic                  norm_done;
    logic signed [NRM_W-1:0] nq_x;
    logic signed [NRM_W-1:0] nq_y;
    logic signed [NRM_W-1:0] nq_z;
    logic                  out_free;

    always_comb begin
        case (cmd.sel)
            SEL_FIRST:  sel_idx = first_reg;
            SEL_SECOND: sel_idx = second_reg;
            SEL_CUR:    sel_idx = idx_reg;
            default:    sel_idx = idx_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg   <= s_tuser;
            idx_reg  <= s_tdata[IDX_W-1:0];
            pos_reg  <= s_tdata[IDX_W +: PW];
            last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg   <= '0;
            second_reg  <= '0;
            prev_reg    <= '0;
            count_reg   <= '0;
            clr_cnt_reg <= '0;
        end else begin
            if (cmd.clr_step) begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            if (cmd.corner_short) begin
                if (count_reg == 2'd0) begin
                    first_reg <= idx_reg;
                    count_reg <= last_reg ? 2'd0 : 2'd1;
                end else begin
                    second_reg <= idx_reg;
                    prev_reg   <= idx_reg;
                    count_reg  <= last_reg ? 2'd0 : 2'd2;
                end
            end
            if (cmd.tri_emit) begin
                prev_reg  <= idx_reg;
                count_reg <= last_reg ? 2'd0 : 2'd3;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pos_write && in_range(idx_reg)) begin
            pos_mem[to_addr(idx_reg)] <= pos_reg;
        end
        if (cmd.pos_rd) begin
            pos_rdata_reg <= pos_mem[to_addr(sel_idx)];
            pos_rng_reg   <= in_range(sel_idx);
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sum_add[k*SUM_WIDTH +: SUM_WIDTH] = '0;
        end
        sum_add[0 +: SUM_WIDTH] = sat_add($signed(sum_rdata_reg[0 +: SUM_WIDTH]), fx_reg);
        sum_add[SUM_WIDTH +: SUM_WIDTH] =
            sat_add($signed(sum_rdata_reg[SUM_WIDTH +: SUM_WIDTH]), fy_reg);
        sum_add[2*SUM_WIDTH +: SUM_WIDTH] =
            sat_add($signed(sum_rdata_reg[2*SUM_WIDTH +: SUM_WIDTH]), fz_reg);
    end

    always_comb begin
        sum_we    = 1'b0;
        sum_waddr = to_addr(sel_idx);
        sum_wdata = '0;
        if (cmd.clr_step) begin
            sum_we    = 1'b1;
            sum_waddr = clr_cnt_reg;
        end else if (cmd.pos_write) begin
            sum_we    = in_range(idx_reg);
            sum_waddr = to_addr(idx_reg);
        end else if (cmd.add_wr) begin
            sum_we    = in_range(sel_idx);
            sum_wdata = sum_add;
        end
    end

    always_ff @(posedge aclk) begin
        if (sum_we) begin
            sum_mem[sum_waddr] <= sum_wdata;
        end
        if (cmd.sum_rd || cmd.add_rd) begin
            sum_rdata_reg <= sum_mem[to_addr(sel_idx)];
            sum_rng_reg   <= in_range(sel_idx);
        end
    end

    assign cap_word = pos_rng_reg ? pos_rdata_reg : '0;

    always_ff @(posedge aclk) begin
        if (cmd.pos_cap) begin
            case (cmd.cap_sel)
                SEL_FIRST:  p0_reg <= cap_word;
                SEL_SECOND: p1_reg <= cap_word;
                SEL_CUR:    p2_reg <= cap_word;
                default:    p2_reg <= cap_word;
            endcase
        end
        if (cmd.diff_load) begin
            for (int k = 0; k < 3; k++) begin
                a_reg[k] <= DIFF_W'($signed(p2_reg[k*POS_W +: POS_W]))
                          - DIFF_W'($signed(p0_reg[k*POS_W +: POS_W]));
                b_reg[k] <= DIFF_W'($signed(p1_reg[k*POS_W +: POS_W]))
                          - DIFF_W'($signed(p0_reg[k*POS_W +: POS_W]));
            end
        end
    end

    always_comb begin
        case (mul_cnt_reg)
            3'd0: begin fa = a_reg[1]; fb = b_reg[2]; end
            3'd1: begin fa = a_reg[2]; fb = b_reg[1]; end
            3'd2: begin fa = a_reg[2]; fb = b_reg[0]; end
            3'd3: begin fa = a_reg[0]; fb = b_reg[2]; end
            3'd4: begin fa = a_reg[0]; fb = b_reg[1]; end
            3'd5: begin fa = a_reg[1]; fb = b_reg[0]; end
            default: begin fa = '0; fb = '0; end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_busy_reg <= 1'b0;
            mul_cnt_reg  <= '0;
        end else if (cmd.mul_start) begin
            mul_busy_reg <= 1'b1;
            mul_cnt_reg  <= '0;
        end else if (mul_busy_reg) begin
            mul_cnt_reg <= mul_cnt_reg + 3'd1;
            if (mul_cnt_reg == 3'd6) begin
                mul_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_busy_reg) begin
            prod_reg <= fa * fb;
            case (mul_cnt_reg)
                3'd1: cx_reg <= NORM_IN_W'(prod_reg);
                3'd2: cx_reg <= cx_reg - NORM_IN_W'(prod_reg);
                3'd3: cy_reg <= NORM_IN_W'(prod_reg);
                3'd4: cy_reg <= cy_reg - NORM_IN_W'(prod_reg);
                3'd5: cz_reg <= NORM_IN_W'(prod_reg);
                3'd6: cz_reg <= cz_reg - NORM_IN_W'(prod_reg);
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (cmd.norm_start_cross) begin
            nv_x = cx_reg;
            nv_y = cy_reg;
            nv_z = cz_reg;
        end else if (sum_rng_reg) begin
            nv_x = NORM_IN_W'($signed(sum_rdata_reg[0 +: SUM_WIDTH]));
            nv_y = NORM_IN_W'($signed(sum_rdata_reg[SUM_WIDTH +: SUM_WIDTH]));
            nv_z = NORM_IN_W'($signed(sum_rdata_reg[2*SUM_WIDTH +: SUM_WIDTH]));
        end else begin
            nv_x = '0;
            nv_y = '0;
            nv_z = '0;
        end
    end

    mvn_norm u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.norm_start_sum || cmd.norm_start_cross),
        .vec_x   (nv_x),
        .vec_y   (nv_y),
        .vec_z   (nv_z),
        .done    (norm_done),
        .q_x     (nq_x),
        .q_y     (nq_y),
        .q_z     (nq_z)
    );

    always_ff @(posedge aclk) begin
        if (cmd.face_load) begin
            fx_reg <= nq_x;
            fy_reg <= nq_y;
            fz_reg <= nq_z;
        end
    end

    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.tri_emit || cmd.norm_emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.tri_emit) begin
            m_data_reg <= {{(M_TDATA_W - 3*IDX_W){1'b0}}, idx_reg, prev_reg, first_reg};
            m_user_reg <= KIND_TRI;
        end else if (cmd.norm_emit) begin
            m_data_reg <= {{(M_TDATA_W - 3*IDX_W - 3*NRM_W){1'b0}}, nq_z, nq_y, nq_x,
                           {(3*IDX_W){1'b0}}};
            m_user_reg <= KIND_NORMAL;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    assign status.op        = op_reg;
    assign status.count     = count_reg;
    assign status.clr_done  = (clr_cnt_reg == ADDR_W'(VERTEX_DEPTH - 1));
    assign status.mul_done  = mul_busy_reg && (mul_cnt_reg == 3'd6);
    assign status.norm_done = norm_done;
    assign status.out_free  = out_free;

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.tri_emit || cmd.norm_emit) |-> (!m_valid_reg || m_tready))
        else $error("result loaded over a transaction not yet taken");

endmodule

// ===== src/mvn_ctrl.sv =====
// Controller state machine: sequences memory accesses, the cross product,
// normalizer runs and accumulation for each accepted transaction.
// Depends on mvn_pkg.
module mvn_ctrl
    import mvn_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [16:0] {
        S_CLEAR    = 17'b00000000000000001,
        S_IDLE     = 17'b00000000000000010,
        S_DECODE   = 17'b00000000000000100,
        S_RD_WAIT  = 17'b00000000000001000,
        S_RD_NORM  = 17'b00000000000010000,
        S_EMIT_NRM = 17'b00000000000100000,
        S_P0       = 17'b00000000001000000,
        S_P1       = 17'b00000000010000000,
        S_P2       = 17'b00000000100000000,
        S_P2CAP    = 17'b00000001000000000,
        S_DIFF     = 17'b00000010000000000,
        S_MUL      = 17'b00000100000000000,
        S_NSTART   = 17'b00001000000000000,
        S_FACE     = 17'b00010000000000000,
        S_ADD_RD   = 17'b00100000000000000,
        S_ADD_WR   = 17'b01000000000000000,
        S_EMIT_TRI = 17'b10000000000000000
    } state_t;

    state_t      state_reg;
    state_t      state_next;
    corner_sel_t add_sel_reg;
    corner_sel_t add_sel_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        cmd          = '0;
        cmd.sel      = SEL_CUR;
        cmd.cap_sel  = SEL_FIRST;
        state_next   = state_reg;
        add_sel_next = add_sel_reg;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (status.clr_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                cmd.accept = s_tvalid;
                if (s_tvalid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                case (status.op)
                    OP_WRITE: begin
                        cmd.pos_write = 1'b1;
                        state_next    = S_IDLE;
                    end
                    OP_READ: begin
                        cmd.sum_rd = 1'b1;
                        state_next = S_RD_WAIT;
                    end
                    OP_CORNER: begin
                        if (status.count == 2'd0 || status.count == 2'd1) begin
                            cmd.corner_short = 1'b1;
                            state_next       = S_IDLE;
                        end else if (status.count == 2'd2) begin
                            state_next = S_P0;
                        end else begin
                            add_sel_next = SEL_CUR;
                            state_next   = S_ADD_RD;
                        end
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_RD_WAIT: begin
                cmd.norm_start_sum = 1'b1;
                state_next         = S_RD_NORM;
            end
            S_RD_NORM: begin
                if (status.norm_done) begin
                    state_next = S_EMIT_NRM;
                end
            end
            S_EMIT_NRM: begin
                if (status.out_free) begin
                    cmd.norm_emit = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_P0: begin
                cmd.pos_rd = 1'b1;
                cmd.sel    = SEL_FIRST;
                state_next = S_P1;
            end
            S_P1: begin
                cmd.pos_rd  = 1'b1;
                cmd.sel     = SEL_SECOND;
                cmd.pos_cap = 1'b1;
                cmd.cap_sel = SEL_FIRST;
                state_next  = S_P2;
            end
            S_P2: begin
                cmd.pos_rd  = 1'b1;
                cmd.sel     = SEL_CUR;
                cmd.pos_cap = 1'b1;
                cmd.cap_sel = SEL_SECOND;
                state_next  = S_P2CAP;
            end
            S_P2CAP: begin
                cmd.pos_cap = 1'b1;
                cmd.cap_sel = SEL_CUR;
                state_next  = S_DIFF;
            end
            S_DIFF: begin
                cmd.diff_load = 1'b1;
                cmd.mul_start = 1'b1;
                state_next    = S_MUL;
            end
            S_MUL: begin
                if (status.mul_done) begin
                    state_next = S_NSTART;
                end
            end
            S_NSTART: begin
                cmd.norm_start_cross = 1'b1;
                state_next           = S_FACE;
            end
            S_FACE: begin
                if (status.norm_done) begin
                    cmd.face_load = 1'b1;
                    add_sel_next  = SEL_FIRST;
                    state_next    = S_ADD_RD;
                end
            end
            S_ADD_RD: begin
                cmd.add_rd = 1'b1;
                cmd.sel    = add_sel_reg;
                state_next = S_ADD_WR;
            end
            S_ADD_WR: begin
                cmd.add_wr = 1'b1;
                cmd.sel    = add_sel_reg;
                case (add_sel_reg)
                    SEL_FIRST: begin
                        add_sel_next = SEL_SECOND;
                        state_next   = S_ADD_RD;
                    end
                    SEL_SECOND: begin
                        add_sel_next = SEL_CUR;
                        state_next   = S_ADD_RD;
                    end
                    default: begin
                        state_next = S_EMIT_TRI;
                    end
                endcase
            end
            S_EMIT_TRI: begin
                if (status.out_free) begin
                    cmd.tri_emit = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            add_sel_reg <= SEL_FIRST;
        end else begin
            state_reg   <= state_next;
            add_sel_reg <= add_sel_next;
        end
    end

    a_accept_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == S_DECODE))
        else $error("accepted transaction was not decoded");

    a_last_add: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ADD_WR && add_sel_reg == SEL_CUR) |=> (state_reg == S_EMIT_TRI))
        else $error("triangle not emitted after the current corner update");

endmodule
